@@ sv/bzs_pkg.sv @@
// shared types and constants for the cubic bezier subdivision core
// no dependencies; used by every module of the block
package bzs_pkg;

   localparam int COORD_W   = 32;
   localparam int T_W       = 17;
   localparam int FRAC_BITS = 16;
   localparam int NUM_PTS   = 7;
   localparam int IDX_W     = 3;

   localparam logic [T_W-1:0]   T_ONE    = 17'h10000;
   localparam logic [IDX_W-1:0] LAST_IDX = 3'd6;
   localparam logic [IDX_W-1:0] GAP_MAX  = 3'd6;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [NUM_PTS-1:0][COORD_W-1:0] pts_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] p0_x;
      logic signed [COORD_W-1:0] p0_y;
      logic signed [COORD_W-1:0] p1_x;
      logic signed [COORD_W-1:0] p1_y;
      logic signed [COORD_W-1:0] p2_x;
      logic signed [COORD_W-1:0] p2_y;
      logic signed [COORD_W-1:0] p3_x;
      logic signed [COORD_W-1:0] p3_y;
      logic [T_W-1:0]            split_t;
   } bzs_req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic [IDX_W-1:0]          point_index;
      logic                      last;
   } bzs_rsp_type;

endpackage

@@ sv/bzs_lerp.sv @@
// two-stage fixed point interpolation unit: a + ((b - a) * t) >>> 16
// depends on bzs_pkg
module bzs_lerp (
   input  logic                  clock,
   input  bzs_pkg::coord_type    a,
   input  bzs_pkg::coord_type    b,
   input  logic [bzs_pkg::T_W-1:0] t,
   output bzs_pkg::coord_type    res
);

   logic signed [bzs_pkg::COORD_W:0]                      diff;
   logic signed [bzs_pkg::COORD_W+bzs_pkg::T_W+1:0]       prod_in;
   logic signed [bzs_pkg::COORD_W+bzs_pkg::T_W+1:0]       prod_ff;
   bzs_pkg::coord_type                                    a_ff;
   bzs_pkg::coord_type                                    res_in;
   bzs_pkg::coord_type                                    res_ff;

   always_comb begin
      diff    = $signed({b[bzs_pkg::COORD_W-1], b}) - $signed({a[bzs_pkg::COORD_W-1], a});
      prod_in = diff * $signed({1'b0, t});
      res_in  = a_ff
              + prod_ff[bzs_pkg::FRAC_BITS+bzs_pkg::COORD_W-1:bzs_pkg::FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      a_ff    <= a;
      res_ff  <= res_in;
   end

   assign res = res_ff;

endmodule

@@ sv/bzs_lane.sv @@
// one coordinate lane: three interpolation levels with aligned delay taps
// depends on bzs_pkg and bzs_lerp
module bzs_lane (
   input  logic                    clock,
   input  bzs_pkg::coord_type      c0,
   input  bzs_pkg::coord_type      c1,
   input  bzs_pkg::coord_type      c2,
   input  bzs_pkg::coord_type      c3,
   input  logic [bzs_pkg::T_W-1:0] t,
   output bzs_pkg::pts_type        pts
);

   bzs_pkg::coord_type c01, c12, c23, cl, cr, cs;

   logic [bzs_pkg::T_W-1:0] t_ff  [4];
   bzs_pkg::coord_type      c0_ff [6];
   bzs_pkg::coord_type      c3_ff [6];
   bzs_pkg::coord_type      c01_ff[4];
   bzs_pkg::coord_type      c23_ff[4];
   bzs_pkg::coord_type      cl_ff [2];
   bzs_pkg::coord_type      cr_ff [2];

   // level one
   bzs_lerp u_l01 (.clock(clock), .a(c0),  .b(c1),  .t(t),        .res(c01));
   bzs_lerp u_l12 (.clock(clock), .a(c1),  .b(c2),  .t(t),        .res(c12));
   bzs_lerp u_l23 (.clock(clock), .a(c2),  .b(c3),  .t(t),        .res(c23));
   // level two
   bzs_lerp u_ll  (.clock(clock), .a(c01), .b(c12), .t(t_ff[1]),  .res(cl));
   bzs_lerp u_lr  (.clock(clock), .a(c12), .b(c23), .t(t_ff[1]),  .res(cr));
   // split point
   bzs_lerp u_ls  (.clock(clock), .a(cl),  .b(cr),  .t(t_ff[3]),  .res(cs));

   always_ff @(posedge clock) begin
      t_ff[0]   <= t;
      c0_ff[0]  <= c0;
      c3_ff[0]  <= c3;
      c01_ff[0] <= c01;
      c23_ff[0] <= c23;
      cl_ff[0]  <= cl;
      cr_ff[0]  <= cr;
      for (int i = 1; i < 4; i++) begin
         t_ff[i]   <= t_ff[i-1];
         c01_ff[i] <= c01_ff[i-1];
         c23_ff[i] <= c23_ff[i-1];
      end
      for (int i = 1; i < 6; i++) begin
         c0_ff[i] <= c0_ff[i-1];
         c3_ff[i] <= c3_ff[i-1];
      end
      cl_ff[1] <= cl_ff[0];
      cr_ff[1] <= cr_ff[0];
   end

   // point order: start, level one left, level two left, split, level two right,
   // level one right, end
   assign pts[0] = c0_ff[5];
   assign pts[1] = c01_ff[3];
   assign pts[2] = cl_ff[1];
   assign pts[3] = cs;
   assign pts[4] = cr_ff[1];
   assign pts[5] = c23_ff[3];
   assign pts[6] = c3_ff[5];

endmodule

@@ sv/bzs_merge.sv @@
// merging stage: joins both lanes and serializes seven points, one word a cycle
// depends on bzs_pkg
module bzs_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  bzs_pkg::pts_type      pts_x,
   input  bzs_pkg::pts_type      pts_y,
   output logic                  rsp_valid,
   output bzs_pkg::bzs_rsp_type  rsp_data
);

   bzs_pkg::coord_type          x_ff [bzs_pkg::NUM_PTS];
   bzs_pkg::coord_type          y_ff [bzs_pkg::NUM_PTS];
   logic [bzs_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic                        active_ff, active_in;

   always_comb begin
      if (load) begin
         idx_in    = '0;
         active_in = 1'b1;
      end else if (active_ff) begin
         idx_in    = idx_ff + 3'd1;
         active_in = (idx_ff != bzs_pkg::LAST_IDX);
      end else begin
         idx_in    = idx_ff;
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         active_ff <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < bzs_pkg::NUM_PTS; i++) begin
            x_ff[i] <= pts_x[i];
            y_ff[i] <= pts_y[i];
         end
      end else begin
         for (int i = 0; i < bzs_pkg::NUM_PTS - 1; i++) begin
            x_ff[i] <= x_ff[i+1];
            y_ff[i] <= y_ff[i+1];
         end
      end
   end

   assign rsp_valid            = active_ff;
   assign rsp_data.out_x       = x_ff[0];
   assign rsp_data.out_y       = y_ff[0];
   assign rsp_data.point_index = idx_ff;
   assign rsp_data.last        = (idx_ff == bzs_pkg::LAST_IDX);

endmodule

@@ sv/cubic_bezier_subdivide_core.sv @@
// top level of the cubic bezier subdivision core: x and y lanes plus merge stage
// depends on bzs_pkg, bzs_lane, bzs_lerp and bzs_merge

// Each accepted request (start high while busy is low) splits one cubic curve
// at split_t and returns seven words on consecutive cycles, marked by rsp_valid:
// the first curve's four points, then the second curve's last three points,
// with last set on point_index 6. The first word comes out of the six-stage
// interpolation pipeline of each lane and then the load register of the merge
// stage. Busy is raised after each accept and holds off further requests, so
// that the single result port, which carries one point per cycle, never holds
// the words of two requests at once. The receiver cannot stall the result words.
module cubic_bezier_subdivide_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bzs_pkg::bzs_req_type  req_data,
   output logic                  rsp_valid,
   output bzs_pkg::bzs_rsp_type  rsp_data
);

   logic                       accept;
   logic [bzs_pkg::T_W-1:0]    t_sat;
   logic [bzs_pkg::IDX_W-1:0]  gap_ff, gap_in;
   logic [5:0]                 vld_ff;
   bzs_pkg::pts_type           pts_x, pts_y;

   assign accept = start && !busy;
   assign busy   = (gap_ff != '0);

   // t above one saturates to one
   always_comb begin
      if (req_data.split_t > bzs_pkg::T_ONE) begin
         t_sat = bzs_pkg::T_ONE;
      end else begin
         t_sat = req_data.split_t;
      end
   end

   always_comb begin
      if (accept) begin
         gap_in = bzs_pkg::GAP_MAX;
      end else if (gap_ff != '0) begin
         gap_in = gap_ff - 3'd1;
      end else begin
         gap_in = gap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= '0;
         vld_ff <= '0;
      end else begin
         gap_ff <= gap_in;
         vld_ff <= {vld_ff[4:0], accept};
      end
   end

   bzs_lane u_lane_x (
      .clock (clock),
      .c0    (req_data.p0_x),
      .c1    (req_data.p1_x),
      .c2    (req_data.p2_x),
      .c3    (req_data.p3_x),
      .t     (t_sat),
      .pts   (pts_x)
   );

   bzs_lane u_lane_y (
      .clock (clock),
      .c0    (req_data.p0_y),
      .c1    (req_data.p1_y),
      .c2    (req_data.p2_y),
      .c3    (req_data.p3_y),
      .t     (t_sat),
      .pts   (pts_y)
   );

   bzs_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (vld_ff[5]),
      .pts_x     (pts_x),
      .pts_y     (pts_y),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after accept");

   a_accept_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##7 (rsp_valid && rsp_data.point_index == '0))
      else $error("first point not on time");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |=> rsp_valid)
      else $error("point run broken");

endmodule

@@ tb/tb.sv @@
// testbench for cubic_bezier_subdivide_core: directed table then random curves
// predicts all seven split points per request and checks every rsp word in order
// depends on bzs_pkg and the cubic_bezier_subdivide_core rtl
`timescale 1ns / 1ps

module tb;

   typedef logic [bzs_pkg::COORD_W-1:0] coord_row_type [bzs_pkg::NUM_PTS];

   typedef struct {
      bzs_pkg::bzs_req_type word;
      bit                   typed;
      coord_row_type        ex;
      coord_row_type        ey;
   } curve_row_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   bzs_pkg::bzs_req_type req_data;
   logic                 rsp_valid;
   bzs_pkg::bzs_rsp_type rsp_data;

   bzs_pkg::bzs_rsp_type pending_points [$];
   curve_row_type        curve_plan [$];
   coord_row_type        no_coords = '{default: '0};
   int                   mismatch_count = 0;

   cubic_bezier_subdivide_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("cubic_bezier_subdivide_core verification failed");
      $finish;
   end

   function automatic longint lerp_q16(longint a, longint b, longint t);
      longint prod;
      prod = (b - a) * t;
      return a + (prod >>> bzs_pkg::FRAC_BITS);
   endfunction

   function automatic void push_point(int k, longint x, longint y);
      bzs_pkg::bzs_rsp_type p;
      p.out_x       = x[bzs_pkg::COORD_W-1:0];
      p.out_y       = y[bzs_pkg::COORD_W-1:0];
      p.point_index = k[bzs_pkg::IDX_W-1:0];
      p.last        = (k[bzs_pkg::IDX_W-1:0] == bzs_pkg::LAST_IDX);
      pending_points.push_back(p);
   endfunction

   // de casteljau split of one curve, seven points queued in output order
   function automatic void split_curve(bzs_pkg::bzs_req_type w);
      longint t, x0, y0, x1, y1, x2, y2, x3, y3;
      longint x01, y01, x12, y12, x23, y23, xl, yl, xr, yr, xs, ys;
      t   = (w.split_t > bzs_pkg::T_ONE) ? longint'(bzs_pkg::T_ONE)
                                         : longint'(w.split_t);
      x0  = longint'($signed(w.p0_x));
      y0  = longint'($signed(w.p0_y));
      x1  = longint'($signed(w.p1_x));
      y1  = longint'($signed(w.p1_y));
      x2  = longint'($signed(w.p2_x));
      y2  = longint'($signed(w.p2_y));
      x3  = longint'($signed(w.p3_x));
      y3  = longint'($signed(w.p3_y));
      x01 = lerp_q16(x0, x1, t);
      y01 = lerp_q16(y0, y1, t);
      x12 = lerp_q16(x1, x2, t);
      y12 = lerp_q16(y1, y2, t);
      x23 = lerp_q16(x2, x3, t);
      y23 = lerp_q16(y2, y3, t);
      xl  = lerp_q16(x01, x12, t);
      yl  = lerp_q16(y01, y12, t);
      xr  = lerp_q16(x12, x23, t);
      yr  = lerp_q16(y12, y23, t);
      xs  = lerp_q16(xl, xr, t);
      ys  = lerp_q16(yl, yr, t);
      push_point(0, x0, y0);
      push_point(1, x01, y01);
      push_point(2, xl, yl);
      push_point(3, xs, ys);
      push_point(4, xr, yr);
      push_point(5, x23, y23);
      push_point(6, x3, y3);
   endfunction

   function automatic bzs_pkg::bzs_req_type make_curve(
                                              logic [31:0] x0, logic [31:0] y0,
                                              logic [31:0] x1, logic [31:0] y1,
                                              logic [31:0] x2, logic [31:0] y2,
                                              logic [31:0] x3, logic [31:0] y3,
                                              logic [bzs_pkg::T_W-1:0] t);
      bzs_pkg::bzs_req_type w;
      w.p0_x    = x0;
      w.p0_y    = y0;
      w.p1_x    = x1;
      w.p1_y    = y1;
      w.p2_x    = x2;
      w.p2_y    = y2;
      w.p3_x    = x3;
      w.p3_y    = y3;
      w.split_t = t;
      return w;
   endfunction

   function automatic void add_row(bzs_pkg::bzs_req_type w, bit typed,
                                   coord_row_type ex, coord_row_type ey);
      curve_row_type r;
      r.word  = w;
      r.typed = typed;
      r.ex    = ex;
      r.ey    = ey;
      curve_plan.push_back(r);
   endfunction

   function automatic logic [31:0] rand_coord();
      logic [31:0] v;
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 3))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'h0000_0000;
               default: v = 32'hFFFF_FFFF;
            endcase
         end
         1, 2: v = 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic logic [bzs_pkg::T_W-1:0] rand_split_t();
      logic [bzs_pkg::T_W-1:0] t;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 5))
               0: t = '0;
               1: t = 17'd1;
               2: t = 17'h0FFFF;
               3: t = bzs_pkg::T_ONE;
               4: t = 17'h10001;
               default: t = 17'h1FFFF;
            endcase
         end
         1, 2: t = bzs_pkg::T_W'($urandom_range(65537, 131071));
         default: t = bzs_pkg::T_W'($urandom_range(0, 65536));
      endcase
      return t;
   endfunction

   function automatic bzs_pkg::bzs_req_type random_curve();
      return make_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                        rand_split_t());
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         return 0;
      end else if (r < 80) begin
         return $urandom_range(1, 13);
      end else if (r < 95) begin
         return $urandom_range(14, 30);
      end else begin
         return $urandom_range(40, 100);
      end
   endfunction

   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch: %s got %h want %h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   task automatic send_curve(bzs_pkg::bzs_req_type w, bit typed, coord_row_type ex,
                             coord_row_type ey, int gap);
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      if (typed) begin
         for (int k = 0; k < bzs_pkg::NUM_PTS; k++) begin
            push_point(k, longint'($signed(ex[k])), longint'($signed(ey[k])));
         end
      end else begin
         split_curve(w);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_points();
      start <= 1'b0;
      do @(posedge clock); while (pending_points.size() != 0);
   endtask

   always @(posedge clock) begin : rsp_check
      bzs_pkg::bzs_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_points.size() == 0) begin
            flag_mismatch("word with nothing pending, out_x", rsp_data.out_x, '0);
         end else begin
            want = pending_points.pop_front();
            if (rsp_data.out_x !== want.out_x)
               flag_mismatch("out_x", rsp_data.out_x, want.out_x);
            if (rsp_data.out_y !== want.out_y)
               flag_mismatch("out_y", rsp_data.out_y, want.out_y);
            if (rsp_data.point_index !== want.point_index)
               flag_mismatch("point_index", 32'(rsp_data.point_index),
                             32'(want.point_index));
            if (rsp_data.last !== want.last)
               flag_mismatch("last", 32'(rsp_data.last), 32'(want.last));
         end
      end
   end

   initial begin
      int burst_left;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;

      // t = 0 collapses the left curve onto p0
      add_row(make_curve(32'h0001_0000, 32'hFFFF_0000, 32'h0005_0000, 32'h0003_0000,
                         32'hFFF8_0000, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         17'h00000), 1'b1,
              '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                32'h0005_0000, 32'hFFF8_0000, 32'h7FFF_FFFF},
              '{32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000,
                32'h0003_0000, 32'h0002_0000, 32'h8000_0000});
      // t = 1.0 and saturated t collapse the right curve onto p3
      add_row(make_curve(32'h0001_0000, 32'hFFFF_0000, 32'h0005_0000, 32'h0003_0000,
                         32'hFFF8_0000, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         bzs_pkg::T_ONE), 1'b1,
              '{32'h0001_0000, 32'h0005_0000, 32'hFFF8_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
              '{32'hFFFF_0000, 32'h0003_0000, 32'h0002_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
      add_row(make_curve(32'h0001_0000, 32'hFFFF_0000, 32'h0005_0000, 32'h0003_0000,
                         32'hFFF8_0000, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         17'h10001), 1'b1,
              '{32'h0001_0000, 32'h0005_0000, 32'hFFF8_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
              '{32'hFFFF_0000, 32'h0003_0000, 32'h0002_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
      add_row(make_curve(32'h0001_0000, 32'hFFFF_0000, 32'h0005_0000, 32'h0003_0000,
                         32'hFFF8_0000, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         17'h1FFFF), 1'b1,
              '{32'h0001_0000, 32'h0005_0000, 32'hFFF8_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
              '{32'hFFFF_0000, 32'h0003_0000, 32'h0002_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
      // degenerate curves stay put for any t
      add_row(make_curve('0, '0, '0, '0, '0, '0, '0, '0, 17'h08000), 1'b1,
              '{default: 32'h0}, '{default: 32'h0});
      add_row(make_curve('1, '1, '1, '1, '1, '1, '1, '1, 17'h1FFFF), 1'b1,
              '{default: 32'hFFFF_FFFF}, '{default: 32'hFFFF_FFFF});
      add_row(make_curve(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         17'h0ABCD), 1'b1,
              '{default: 32'h7FFF_FFFF}, '{default: 32'h8000_0000});
      // full-range swings between the coordinate extremes, and small swings around zero
      add_row(make_curve(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                         17'h08000), 1'b0, no_coords, no_coords);
      add_row(make_curve(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                         17'h00001), 1'b0, no_coords, no_coords);
      add_row(make_curve(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                         17'h0FFFF), 1'b0, no_coords, no_coords);
      add_row(make_curve(32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                         32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                         17'h04000), 1'b0, no_coords, no_coords);
      add_row(make_curve(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF,
                         32'hFFFF_FFFE, 32'h0000_0002, 32'h0000_0003, 32'hFFFF_FFFD,
                         17'h0C000), 1'b0, no_coords, no_coords);
      // small negative deltas exercise floor rounding of the shift
      add_row(make_curve(32'h0000_0005, 32'hFFFF_FFFB, 32'h0000_0000, 32'h0000_0000,
                         32'h0000_0007, 32'hFFFF_FFF9, 32'hFFFF_FFF0, 32'h0000_0010,
                         17'h05555), 1'b0, no_coords, no_coords);
      add_row(make_curve(32'h0010_8000, 32'hFFE0_4000, 32'hFFF0_0001, 32'h0033_3333,
                         32'h1234_5678, 32'hEDCB_A987, 32'hFF00_FF00, 32'h00FF_00FF,
                         17'h0AAAA), 1'b0, no_coords, no_coords);
      add_row(make_curve(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                         32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                         17'h15555), 1'b0, no_coords, no_coords);
      add_row(make_curve(32'h0000_0000, 32'h0000_0000, 32'h0003_0000, 32'h0004_0000,
                         32'h0006_0000, 32'h0000_0000, 32'h0009_0000, 32'h0004_0000,
                         17'h0FFFF), 1'b0, no_coords, no_coords);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (curve_plan[i]) begin
         send_curve(curve_plan[i].word, curve_plan[i].typed, curve_plan[i].ex,
                    curve_plan[i].ey, (i % 3 == 0) ? 0 : pick_gap());
      end
      drain_points();

      burst_left = 0;
      for (int n = 0; n < 260; n++) begin
         if (n % 45 == 0)
            burst_left = 12;
         if (n == 130)
            drain_points();
         if (burst_left > 0) begin
            burst_left--;
            send_curve(random_curve(), 1'b0, no_coords, no_coords, 0);
         end else begin
            send_curve(random_curve(), 1'b0, no_coords, no_coords, pick_gap());
         end
      end

      drain_points();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("cubic_bezier_subdivide_core verification clean");
      end else begin
         $display("cubic_bezier_subdivide_core verification failed");
      end
      $finish;
   end

endmodule
